// File: rtl/core/kmp_pkg.sv
// Shared widths, action codes and queue word type for the KMP stream matcher.
package kmp_pkg;

    localparam int ACTION_W        = 2;
    localparam int PIDX_W          = 5;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 6;
    localparam int POS_W           = 32;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    // Action codes carried by an input word
    typedef enum logic [ACTION_W-1:0] {
        ACT_PATTERN = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    // Word held in the queue between front and back end
    typedef struct packed {
        t_action                 op;
        logic [PIDX_W-1:0]       pattern_index;
        logic [BYTE_W-1:0]       data_byte;
    } t_cmd;

endpackage

// File: rtl/core/kmp_stream_if.sv
// Valid/ready channel interfaces for input words and result words.
interface kmp_in_if;
    logic                          valid;
    logic                          ready;
    logic [kmp_pkg::ACTION_W-1:0]  action;
    logic [kmp_pkg::PIDX_W-1:0]    pattern_index;
    logic [kmp_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, action, pattern_index, data_byte, input ready);
    modport sink   (input valid, action, pattern_index, data_byte, output ready);
endinterface

interface kmp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [kmp_pkg::POS_W-1:0]     start_position;

    modport source (output valid, found, start_position, input ready);
    modport sink   (input valid, found, start_position, output ready);
endinterface

// File: rtl/core/kmp_stream_matcher.sv
// Top level of the KMP stream matcher: front end, queue and back end.
//
// Streaming Knuth-Morris-Pratt matcher with the strong failure table. Input
// words are taken whenever the two-word queue in the front end has room. A
// result that waits for the receiver holds the back end at the end of the next
// text word, so the queue fills and input then stalls. In the back end a text
// word follows failure links until its byte matches or no link is left, and
// over a stream the links followed never outnumber the text bytes. A restart
// rebuilds the failure table one pattern position after another. The failure
// table has a single registered read port, which allows one link per cycle.
// pattern_length is latched at restart, and text matched before the first
// restart gives undefined results.
module kmp_stream_matcher #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [kmp_pkg::LEN_W-1:0] i_cfg_wdata,
    kmp_in_if.sink                    i_in,
    kmp_out_if.source                 o_res
);

    logic          q_valid;
    logic          q_pop;
    kmp_pkg::t_cmd q_cmd;

    // Accept and queue words
    kmp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    // Execute queued words and register results
    kmp_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res       (o_res)
    );

endmodule

// File: rtl/core/kmp_front.sv
// Front end: accept input words, drop unused actions and queue the rest.
module kmp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    kmp_in_if.sink         i_in,
    output logic           o_q_valid,
    output kmp_pkg::t_cmd  o_q_cmd,
    input  logic           i_q_pop
);

    localparam int QD  = kmp_pkg::QUEUE_DEPTH;
    localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW  = $clog2(QD + 1);

    kmp_pkg::t_cmd    r_q [QD];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [CW-1:0]    r_cnt;
    logic             keep;
    logic             push;
    kmp_pkg::t_cmd    cmd;

    // Classify the action: only the three defined codes reach the back end
    always_comb begin
        unique case (i_in.action) inside
            kmp_pkg::ACT_PATTERN, kmp_pkg::ACT_TEXT, kmp_pkg::ACT_RESTART: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    always_comb begin
        cmd.op            = kmp_pkg::t_action'(i_in.action);
        cmd.pattern_index = i_in.pattern_index;
        cmd.data_byte     = i_in.data_byte;
    end

    assign i_in.ready = (r_cnt != CW'(QD));
    assign push       = i_in.valid && i_in.ready && keep;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_cmd    = r_q[r_rp];

    // Store a word at the write pointer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPW'(QD - 1)) ? '0 : r_wp + QPW'(1);
            end
            if (i_q_pop) begin
                r_rp <= (r_rp == QPW'(QD - 1)) ? '0 : r_rp + QPW'(1);
            end
            r_cnt <= r_cnt + CW'(push) - CW'(i_q_pop);
        end
    end

endmodule

// File: rtl/core/kmp_back.sv
// Back end: pattern store, failure table, rebuild and text matching sequencer.
module kmp_back #(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [kmp_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                      i_q_valid,
    input  kmp_pkg::t_cmd             i_q_cmd,
    output logic                      o_q_pop,
    kmp_out_if.source                 o_res
);

    localparam int IW  = $clog2(MAX_PATTERN + 2);
    localparam int AW  = $clog2(MAX_PATTERN);
    localparam int FAW = $clog2(MAX_PATTERN + 1);
    localparam int FTW = $clog2(MAX_PATTERN + 1);
    localparam int PW  = kmp_pkg::POS_W;
    localparam int BW  = kmp_pkg::BYTE_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_T_CMP = 4'b0010,
        S_R_CHK = 4'b0100,
        S_R_WR  = 4'b1000
    } t_state;

    // Storage
    logic [BW-1:0]  r_pm [MAX_PATTERN];
    logic [FTW-1:0] r_ft [MAX_PATTERN + 1];
    logic [BW-1:0]  r_pa_q;
    logic [BW-1:0]  r_pb_q;
    logic [FTW-1:0] r_f_q;

    // Control and working registers
    t_state                    r_state, n_state;
    logic [IW-1:0]             r_i, n_i;
    logic [IW-1:0]             r_j, n_j;
    logic [IW-1:0]             r_m, n_m;
    logic [IW-1:0]             r_match, n_match;
    logic [PW-1:0]             r_pos, n_pos;
    logic [BW-1:0]             r_byte, n_byte;
    logic [FTW-1:0]            r_ft_end, n_ft_end;
    logic [kmp_pkg::LEN_W-1:0] r_len;
    logic                      r_out_valid;
    logic                      r_found;
    logic [PW-1:0]             r_start;

    // Combinational helpers
    logic [AW-1:0]  addr_a;
    logic [AW-1:0]  addr_b;
    logic [FAW-1:0] addr_f;
    logic           pm_we;
    logic           ft_we;
    logic [FAW-1:0] ft_waddr;
    logic [FTW-1:0] ft_wdata;
    logic           load_out;
    logic           out_found;
    logic [PW-1:0]  out_start;
    logic           out_free;
    logic [IW-1:0]  len_clamped;
    logic [IW-1:0]  text_i;
    logic [IW-1:0]  next_i;
    logic [IW-1:0]  link_i;
    logic [IW-1:0]  link_j;
    logic [IW-1:0]  wr_val;
    logic [PW-1:0]  pos_inc;

    assign out_free = !r_out_valid || o_res.ready;
    assign pos_inc  = r_pos + PW'(1);
    assign next_i   = r_i + IW'(1);
    assign link_i   = IW'(r_f_q);
    assign link_j   = IW'(r_f_q);
    assign text_i   = (r_match > r_m) ? r_m : r_match;
    assign wr_val   = ((r_i == r_m) || (r_pa_q != r_pb_q)) ? r_j : IW'(r_f_q);

    // Clamp the configured length into 1..MAX_PATTERN
    always_comb begin
        if (r_len == '0) begin
            len_clamped = IW'(1);
        end else if (32'(r_len) > 32'(MAX_PATTERN)) begin
            len_clamped = IW'(MAX_PATTERN);
        end else begin
            len_clamped = IW'(r_len);
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_m       = r_m;
        n_match   = r_match;
        n_pos     = r_pos;
        n_byte    = r_byte;
        n_ft_end  = r_ft_end;
        addr_a    = AW'(r_i - IW'(1));
        addr_b    = AW'(r_j - IW'(1));
        addr_f    = FAW'(r_i - IW'(1));
        pm_we     = 1'b0;
        ft_we     = 1'b0;
        ft_waddr  = FAW'(r_i);
        ft_wdata  = FTW'(wr_val);
        o_q_pop   = 1'b0;
        load_out  = 1'b0;
        out_found = 1'b0;
        out_start = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.op)
                        kmp_pkg::ACT_PATTERN: begin
                            pm_we = (32'(i_q_cmd.pattern_index) < 32'(MAX_PATTERN));
                        end
                        kmp_pkg::ACT_TEXT: begin
                            n_byte  = i_q_cmd.data_byte;
                            n_i     = text_i;
                            addr_a  = AW'(text_i - IW'(1));
                            addr_f  = FAW'(text_i - IW'(1));
                            n_state = S_T_CMP;
                        end
                        kmp_pkg::ACT_RESTART: begin
                            // Latch length, seed first table entry, fetch first byte
                            n_m      = len_clamped;
                            ft_we    = 1'b1;
                            ft_waddr = '0;
                            ft_wdata = '0;
                            n_i      = IW'(1);
                            n_j      = '0;
                            addr_a   = '0;
                            n_state  = S_R_CHK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_T_CMP: begin
                if ((r_i == '0) || (r_pa_q == r_byte)) begin
                    // Finish the word once the output register is free; hold otherwise
                    if (out_free) begin
                        load_out = 1'b1;
                        n_pos    = pos_inc;
                        if (next_i == r_m + IW'(1)) begin
                            out_found = 1'b1;
                            out_start = pos_inc - PW'(r_m) + PW'(1);
                            n_match   = IW'(r_ft_end);
                        end else begin
                            n_match = next_i;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    // Follow one failure link
                    n_i    = link_i;
                    addr_a = AW'(link_i - IW'(1));
                    addr_f = FAW'(link_i - IW'(1));
                end
            end

            S_R_CHK: begin
                if ((r_j != '0) && (r_pa_q != r_pb_q)) begin
                    n_j    = link_j;
                    addr_a = AW'(r_i - IW'(1));
                    addr_b = AW'(link_j - IW'(1));
                    addr_f = FAW'(link_j - IW'(1));
                end else begin
                    // Advance j; fetch pat(i+1), pat(j+1) and its link
                    n_j     = r_j + IW'(1);
                    addr_a  = AW'(r_i);
                    addr_b  = AW'(r_j);
                    addr_f  = FAW'(r_j);
                    n_state = S_R_WR;
                end
            end

            S_R_WR: begin
                ft_we    = 1'b1;
                ft_waddr = FAW'(r_i);
                ft_wdata = FTW'(wr_val);
                addr_a   = AW'(r_i);
                addr_b   = AW'(r_j - IW'(1));
                addr_f   = FAW'(r_j - IW'(1));
                if (r_i == r_m) begin
                    n_ft_end = FTW'(wr_val);
                    n_pos    = '0;
                    n_match  = IW'(1);
                    n_state  = S_IDLE;
                end else begin
                    n_i     = next_i;
                    n_state = S_R_CHK;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Pattern store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            r_pm[AW'(i_q_cmd.pattern_index)] <= i_q_cmd.data_byte;
        end
        r_pa_q <= r_pm[addr_a];
        r_pb_q <= r_pm[addr_b];
    end

    // Failure table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ft_we) begin
            r_ft[ft_waddr] <= ft_wdata;
        end
        r_f_q <= r_ft[addr_f];
    end

    // Working registers without reset
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_byte <= n_byte;
        if (load_out) begin
            r_found <= out_found;
            r_start <= out_start;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= IW'(1);
            r_match     <= IW'(1);
            r_pos       <= '0;
            r_ft_end    <= '0;
            r_len       <= kmp_pkg::LEN_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_m      <= n_m;
            r_match  <= n_match;
            r_pos    <= n_pos;
            r_ft_end <= n_ft_end;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.found          = r_found;
    assign o_res.start_position = r_start;

`ifndef ASSERT_OFF
    // A result is raised only by a finished text word
    a_out_from_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_T_CMP))
        else $error("result raised outside text matching");

    // A miss carries a zero start position
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_start == '0))
        else $error("miss with non-zero start position");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_res.ready))
        else $error("pending result overwritten");

    // A finished rebuild leaves position cleared and index at one
    a_restart_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R_WR && n_state == S_IDLE) |=> (r_pos == '0 && r_match == IW'(1)))
        else $error("restart did not clear text state");

    // During rebuild the prefix index never passes the scan index
    a_j_le_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R_CHK || r_state == S_R_WR) |-> (r_j <= r_i))
        else $error("rebuild prefix index beyond scan index");
`endif

endmodule
